>>> rtl/salf_pkg.sv
// ----------------------------------------------------------------------------
// salf_pkg
// Shared types and constants for the signed ALU with factorial unit.
// ----------------------------------------------------------------------------
package salf_pkg;

  // Port field widths
  localparam int DATA_W   = 64;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  // Default arithmetic width
  localparam int WIDTH_DEF = 64;

  // Factorial index counter; 21! already exceeds 64 bits
  localparam int FACT_IW = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
  localparam logic [OP_W-1:0] OP_FACT = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FACTOVF = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

  // Result item as handed from the core to the output register
  typedef struct packed {
    logic [DATA_W-1:0]   result;
    logic [DATA_W-1:0]   remainder;
    logic [STATUS_W-1:0] status;
  } salf_rsp_t;

  // Handshake status between core and top level
  typedef struct packed {
    logic req_ready;
    logic rsp_valid;
  } salf_hs_t;

endpackage

>>> rtl/salf_req_if.sv
// ----------------------------------------------------------------------------
// salf_req_if
// Request channel: operation code and two operands, valid/ready.
// ----------------------------------------------------------------------------
interface salf_req_if;
  logic                          valid;
  logic                          ready;
  logic [salf_pkg::OP_W-1:0]     req_type;
  logic signed [salf_pkg::DATA_W-1:0] operand_a;
  logic signed [salf_pkg::DATA_W-1:0] operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input req_type, input operand_a, input operand_b,
                  output ready);
endinterface

>>> rtl/salf_rsp_if.sv
// ----------------------------------------------------------------------------
// salf_rsp_if
// Response channel: result, remainder and status, valid/ready.
// ----------------------------------------------------------------------------
interface salf_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [salf_pkg::DATA_W-1:0]  result;
  logic signed [salf_pkg::DATA_W-1:0]  remainder;
  logic [salf_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output result, output remainder, output status,
                  input ready);
  modport sink   (input valid, input result, input remainder, input status,
                  output ready);
endinterface

>>> rtl/salf_addsub.sv
// ----------------------------------------------------------------------------
// salf_addsub
// Shared adder/subtractor with carry out; carry set on subtract means x >= y.
// ----------------------------------------------------------------------------
module salf_addsub #(
  parameter int W = 69
) (
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         cout
);

  logic [W:0] full;

  assign full = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{W{1'b0}}, sub};
  assign sum  = full[W-1:0];
  assign cout = full[W];

endmodule

>>> rtl/salf_core.sv
// ----------------------------------------------------------------------------
// salf_core
// Sequencer and datapath around one shared adder: shift-add multiply,
// restoring divide, factorial by repeated short multiplies.
// ----------------------------------------------------------------------------
module salf_core #(
  parameter int WIDTH = salf_pkg::WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_start,
  input  logic [salf_pkg::OP_W-1:0]     req_type,
  input  logic [salf_pkg::DATA_W-1:0]   req_a,
  input  logic [salf_pkg::DATA_W-1:0]   req_b,
  input  logic                          rsp_take,
  output salf_pkg::salf_hs_t            hs,
  output salf_pkg::salf_rsp_t           rsp
);

  localparam int FI = salf_pkg::FACT_IW;
  localparam int XW = WIDTH + FI;
  localparam int CW = $clog2(WIDTH + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DISP = 9'b000000010,
    S_DNEG = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_FCHK = 9'b000100000,
    S_QFIX = 9'b001000000,
    S_RFIX = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [salf_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [WIDTH-1:0]                a_r, a_nxt;
  logic [WIDTH-1:0]                b_r, b_nxt;
  logic [XW-1:0]                   acc_r, acc_nxt;
  logic [WIDTH-1:0]                q_r, q_nxt;
  logic [WIDTH-1:0]                m_r, m_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [FI-1:0]                   fi_r, fi_nxt;
  logic                            negq_r, negq_nxt;
  logic [WIDTH-1:0]                res_r, res_nxt;
  logic [WIDTH-1:0]                rem_r, rem_nxt;
  logic [salf_pkg::STATUS_W-1:0]   st_r, st_nxt;

  logic [XW-1:0] ax, ay, asum;
  logic          asub, acout;
  logic [WIDTH:0] div_shift;

  salf_addsub #(.W(XW)) u_addsub (
    .x    (ax),
    .y    (ay),
    .sub  (asub),
    .sum  (asum),
    .cout (acout)
  );

  assign div_shift = {acc_r[WIDTH-1:0], q_r[WIDTH-1]};

  // Operand select for the shared adder
  always_comb begin
    ax   = '0;
    ay   = '0;
    asub = 1'b0;
    unique case (state_r)
      S_DISP: begin
        if (op_r == salf_pkg::OP_ADD || op_r == salf_pkg::OP_SUB) begin
          ax   = XW'(a_r);
          ay   = XW'(b_r);
          asub = (op_r == salf_pkg::OP_SUB);
        end else begin
          ay   = XW'(a_r);
          asub = 1'b1;
        end
      end
      S_DNEG: begin
        ay   = XW'(b_r);
        asub = 1'b1;
      end
      S_MUL: begin
        ax = {acc_r[XW-2:0], 1'b0};
        ay = q_r[WIDTH-1] ? XW'(m_r) : '0;
      end
      S_DIV: begin
        ax   = XW'(div_shift);
        ay   = XW'(m_r);
        asub = 1'b1;
      end
      S_QFIX: begin
        ay   = XW'(q_r);
        asub = 1'b1;
      end
      S_RFIX: begin
        ay   = XW'(acc_r[WIDTH-1:0]);
        asub = 1'b1;
      end
      default: begin
        ax   = '0;
        ay   = '0;
        asub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    m_nxt     = m_r;
    cnt_nxt   = cnt_r;
    fi_nxt    = fi_r;
    negq_nxt  = negq_r;
    res_nxt   = res_r;
    rem_nxt   = rem_r;
    st_nxt    = st_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_start) begin
          op_nxt    = req_type;
          a_nxt     = req_a[WIDTH-1:0];
          b_nxt     = req_b[WIDTH-1:0];
          res_nxt   = '0;
          rem_nxt   = '0;
          st_nxt    = salf_pkg::ST_OK;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        unique case (op_r)
          salf_pkg::OP_ADD, salf_pkg::OP_SUB: begin
            res_nxt   = asum[WIDTH-1:0];
            state_nxt = S_DONE;
          end
          salf_pkg::OP_MUL: begin
            acc_nxt   = '0;
            q_nxt     = b_r;
            m_nxt     = a_r;
            cnt_nxt   = CW'(WIDTH);
            state_nxt = S_MUL;
          end
          salf_pkg::OP_DIV: begin
            if (b_r == '0) begin
              st_nxt    = salf_pkg::ST_DIVZERO;
              state_nxt = S_DONE;
            end else begin
              q_nxt     = a_r[WIDTH-1] ? asum[WIDTH-1:0] : a_r;
              negq_nxt  = a_r[WIDTH-1] ^ b_r[WIDTH-1];
              state_nxt = S_DNEG;
            end
          end
          salf_pkg::OP_FACT: begin
            m_nxt     = WIDTH'(1);
            fi_nxt    = FI'(2);
            state_nxt = S_FCHK;
          end
          default: begin
            st_nxt    = salf_pkg::ST_UNKNOWN;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DNEG: begin
        m_nxt     = b_r[WIDTH-1] ? asum[WIDTH-1:0] : b_r;
        acc_nxt   = '0;
        cnt_nxt   = CW'(WIDTH);
        state_nxt = S_DIV;
      end

      // One multiplier bit per cycle, MSB first
      S_MUL: begin
        acc_nxt = asum;
        q_nxt   = {q_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          if (op_r == salf_pkg::OP_MUL) begin
            res_nxt   = asum[WIDTH-1:0];
            state_nxt = S_DONE;
          end else if (asum[XW-1:WIDTH] != '0) begin
            st_nxt    = salf_pkg::ST_FACTOVF;
            state_nxt = S_DONE;
          end else begin
            m_nxt     = asum[WIDTH-1:0];
            fi_nxt    = fi_r + FI'(1);
            state_nxt = S_FCHK;
          end
        end
      end

      // Next factor, or finish once the index passes n
      S_FCHK: begin
        if (WIDTH'(fi_r) > a_r) begin
          res_nxt   = m_r;
          state_nxt = S_DONE;
        end else begin
          acc_nxt   = '0;
          q_nxt     = {fi_r, {(WIDTH-FI){1'b0}}};
          cnt_nxt   = CW'(FI);
          state_nxt = S_MUL;
        end
      end

      // Restoring divide, one quotient bit per cycle
      S_DIV: begin
        acc_nxt = acout ? asum : XW'(div_shift);
        q_nxt   = {q_r[WIDTH-2:0], acout};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = S_QFIX;
        end
      end

      S_QFIX: begin
        res_nxt   = negq_r ? asum[WIDTH-1:0] : q_r;
        state_nxt = S_RFIX;
      end

      S_RFIX: begin
        rem_nxt   = a_r[WIDTH-1] ? asum[WIDTH-1:0] : acc_r[WIDTH-1:0];
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (rsp_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    m_r    <= m_nxt;
    cnt_r  <= cnt_nxt;
    fi_r   <= fi_nxt;
    negq_r <= negq_nxt;
    res_r  <= res_nxt;
    rem_r  <= rem_nxt;
    st_r   <= st_nxt;
  end

  assign hs.req_ready = (state_r == S_IDLE);
  assign hs.rsp_valid = (state_r == S_DONE);

  assign rsp.result    = salf_pkg::DATA_W'($signed(res_r));
  assign rsp.remainder = salf_pkg::DATA_W'($signed(rem_r));
  assign rsp.status    = st_r;

endmodule

>>> rtl/signed_alu_with_factorial_unit.sv
// ----------------------------------------------------------------------------
// signed_alu_with_factorial_unit
// Signed integer ALU: add, subtract, multiply, truncating divide, factorial.
// ----------------------------------------------------------------------------
//  channel   dir  fields                          transfer
//  in_req    in   req_type, operand_a, operand_b  valid & ready
//  out_rsp   out  result, remainder, status       valid & ready
//
//  One request at a time through one shared WIDTH+5 bit adder.
//  Factorial multiplies by 2, 3, ... up to n and ends with an overflow status at
//  the first factor k whose product overflows (k is 21 at 64 bits).
//  Output register holds a finished result while the next request is taken;
//  a full, stalled output register holds the core in its done state.
//  Synchronous active-low reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module signed_alu_with_factorial_unit #(
  parameter int WIDTH = salf_pkg::WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  salf_req_if.sink   in_req,
  salf_rsp_if.source out_rsp
);

  salf_pkg::salf_hs_t  hs;
  salf_pkg::salf_rsp_t core_rsp;
  salf_pkg::salf_rsp_t out_r;
  logic                out_valid_r;
  logic                rsp_take;

  assign rsp_take = hs.rsp_valid && (!out_valid_r || out_rsp.ready);

  salf_core #(.WIDTH(WIDTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_start (in_req.valid && hs.req_ready),
    .req_type  (in_req.req_type),
    .req_a     (in_req.operand_a),
    .req_b     (in_req.operand_b),
    .rsp_take  (rsp_take),
    .hs        (hs),
    .rsp       (core_rsp)
  );

  assign in_req.ready = hs.req_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_r <= core_rsp;
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.result    = out_r.result;
  assign out_rsp.remainder = out_r.remainder;
  assign out_rsp.status    = out_r.status;

endmodule

>>> sim/signed_alu_with_factorial_unit_tb.sv
// ----------------------------------------------------------------------------
// signed_alu_with_factorial_unit_tb
// Runs directed corner requests and then random ones through the ALU, with
// random gaps on the request side and random stalls on the response side.
// Every response is compared field by field against a local model of the
// add, subtract, multiply, divide and factorial operations and unknown op codes.
// ----------------------------------------------------------------------------
module signed_alu_with_factorial_unit_tb;

  localparam int DW = salf_pkg::DATA_W;
  localparam int OW = salf_pkg::OP_W;

  localparam logic [DW-1:0] S64_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [DW-1:0] S64_MAX  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [DW-1:0] U64_MAX  = 64'hffff_ffff_ffff_ffff;
  localparam int            RAND_CHUNKS = 8;
  localparam int            CHUNK_LEN   = 50;
  localparam int            LONG_HOLD   = 300;
  localparam int            SETTLE_CYC  = 200;

  typedef struct packed {
    logic [OW-1:0] op;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } alu_req_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  salf_req_if req_ch ();
  salf_rsp_if rsp_ch ();

  signed_alu_with_factorial_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always #4 clk = ~clk;

  alu_req_t            pending_reqs[$];
  salf_pkg::salf_rsp_t expected_rsps[$];

  alu_req_t            tx_item;
  int                  tx_gap;
  bit                  tx_idle_on;
  bit                  rx_idle_on;
  int                  rx_stall;
  int                  rx_hold;
  int                  rx_hold_seq;
  int                  rx_hold_seen;
  int                  rx_draw;
  salf_pkg::salf_rsp_t want;
  salf_pkg::salf_rsp_t got;
  int                  fail_count;
  int                  rsp_count;
  int                  op_hist[8];
  int                  status_hist[4];

  // Expected response for one request, computed at 64 bits
  function automatic salf_pkg::salf_rsp_t alu_predict(logic [OW-1:0] op, logic [DW-1:0] a,
                                                      logic [DW-1:0] b);
    salf_pkg::salf_rsp_t r;
    logic [DW-1:0]       ma;
    logic [DW-1:0]       mb;
    logic [DW-1:0]       q;
    logic [DW-1:0]       rm;
    logic [DW-1:0]       acc;
    longint unsigned     i;
    bit                  ovf;
    r = '0;
    r.status = salf_pkg::ST_OK;
    case (op)
      salf_pkg::OP_ADD: r.result = a + b;
      salf_pkg::OP_SUB: r.result = a - b;
      salf_pkg::OP_MUL: r.result = a * b;
      salf_pkg::OP_DIV: begin
        if (b == '0) begin
          r.status = salf_pkg::ST_DIVZERO;
        end else begin
          // magnitudes divide cleanly even for the most negative value
          ma = a[DW-1] ? -a : a;
          mb = b[DW-1] ? -b : b;
          q  = ma / mb;
          rm = ma % mb;
          r.result    = (a[DW-1] ^ b[DW-1]) ? -q : q;
          r.remainder = a[DW-1] ? -rm : rm;
        end
      end
      salf_pkg::OP_FACT: begin
        acc = 1;
        ovf = 1'b0;
        for (i = 2; i <= a && !ovf; i++) begin
          if (acc > U64_MAX / i) ovf = 1'b1;
          else acc = acc * i;
        end
        if (ovf) r.status = salf_pkg::ST_FACTOVF;
        else r.result = acc;
      end
      default: r.status = salf_pkg::ST_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic void queue_req(logic [OW-1:0] op, logic [DW-1:0] a,
                                    logic [DW-1:0] b);
    alu_req_t it;
    it.op = op;
    it.a  = a;
    it.b  = b;
    pending_reqs.push_back(it);
  endfunction

  // Mix of full-range, small, extreme and variable-magnitude values
  function automatic logic [DW-1:0] rand_operand();
    logic [DW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      1: v = DW'($signed($urandom_range(0, 32)) - 16);
      2: begin
        case ($urandom_range(0, 4))
          0: v = S64_MIN;
          1: v = S64_MAX;
          2: v = '0;
          3: v = 1;
          default: v = U64_MAX;
        endcase
      end
      3: begin
        v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic void queue_random_req();
    logic [OW-1:0] op;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    int            pick;
    pick = $urandom_range(0, 15);
    a = rand_operand();
    b = rand_operand();
    if (pick < 3)       op = salf_pkg::OP_ADD;
    else if (pick < 6)  op = salf_pkg::OP_SUB;
    else if (pick < 9)  op = salf_pkg::OP_MUL;
    else if (pick < 12) op = salf_pkg::OP_DIV;
    else if (pick < 15) op = salf_pkg::OP_FACT;
    else                op = OW'($urandom_range(5, 7));
    if (op == salf_pkg::OP_DIV && $urandom_range(0, 9) == 0) b = '0;
    if (op == salf_pkg::OP_FACT && $urandom_range(0, 3) != 0) a = DW'($urandom_range(0, 24));
    queue_req(op, a, b);
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      tx_gap       <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (tx_gap != 0) begin
        req_ch.valid <= 1'b0;
        tx_gap       <= tx_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        tx_item = pending_reqs.pop_front();
        req_ch.req_type  <= tx_item.op;
        req_ch.operand_a <= tx_item.a;
        req_ch.operand_b <= tx_item.b;
        req_ch.valid     <= 1'b1;
        tx_gap           <= tx_idle_on ? $urandom_range(0, 3) : 0;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response receiver: per-result stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      rx_stall     <= 0;
      rx_hold      <= 0;
      rx_hold_seen <= 0;
    end else if (rx_hold_seen != rx_hold_seq) begin
      rx_hold_seen <= rx_hold_seq;
      rx_hold      <= LONG_HOLD;
      rsp_ch.ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold      <= rx_hold - 1;
      rsp_ch.ready <= (rx_hold == 1);
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      rx_draw = rx_idle_on ? $urandom_range(0, 3) : 0;
      rx_stall     <= rx_draw;
      rsp_ch.ready <= (rx_draw == 0);
    end else if (rx_stall != 0) begin
      rx_stall     <= rx_stall - 1;
      rsp_ch.ready <= (rx_stall == 1);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on request transfer, compare on response transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(alu_predict(req_ch.req_type, req_ch.operand_a,
                                            req_ch.operand_b));
        op_hist[req_ch.req_type]++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.result    = rsp_ch.result;
        got.remainder = rsp_ch.remainder;
        got.status    = rsp_ch.status;
        rsp_count++;
        if (expected_rsps.size() == 0) begin
          note_failure($sformatf("unexpected response %h %h %0d",
                                 got.result, got.remainder, got.status));
        end else begin
          want = expected_rsps.pop_front();
          status_hist[want.status]++;
          if (got.result !== want.result)
            note_failure($sformatf("result expected %h, got %h", want.result, got.result));
          if (got.remainder !== want.remainder)
            note_failure($sformatf("remainder expected %h, got %h",
                                   want.remainder, got.remainder));
          if (got.status !== want.status)
            note_failure($sformatf("status expected %0d, got %0d", want.status, got.status));
        end
      end
    end
  end

  initial begin
    req_ch.valid     = 1'b0;
    req_ch.req_type  = salf_pkg::OP_ADD;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    rsp_ch.ready     = 1'b0;
    fail_count  = 0;
    rsp_count   = 0;
    rx_hold_seq = 0;
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    foreach (op_hist[i]) op_hist[i] = 0;
    foreach (status_hist[i]) status_hist[i] = 0;

    // wrap-around, signed division corners, factorial limits, unknown codes
    queue_req(salf_pkg::OP_ADD, S64_MAX, 1);
    queue_req(salf_pkg::OP_ADD, S64_MIN, S64_MIN);
    queue_req(salf_pkg::OP_ADD, U64_MAX, 1);
    queue_req(salf_pkg::OP_SUB, S64_MIN, 1);
    queue_req(salf_pkg::OP_SUB, '0, S64_MIN);
    queue_req(salf_pkg::OP_MUL, S64_MAX, S64_MAX);
    queue_req(salf_pkg::OP_MUL, S64_MIN, U64_MAX);
    queue_req(salf_pkg::OP_MUL, -64'sd3, 64'sd5);
    queue_req(salf_pkg::OP_DIV, 64'sd7, -64'sd2);
    queue_req(salf_pkg::OP_DIV, -64'sd7, 64'sd2);
    queue_req(salf_pkg::OP_DIV, -64'sd7, -64'sd2);
    queue_req(salf_pkg::OP_DIV, 64'sd12345, '0);
    queue_req(salf_pkg::OP_DIV, S64_MIN, U64_MAX);
    queue_req(salf_pkg::OP_DIV, S64_MIN, 1);
    queue_req(salf_pkg::OP_DIV, S64_MAX, S64_MIN);
    queue_req(salf_pkg::OP_DIV, '0, -64'sd9);
    queue_req(salf_pkg::OP_FACT, '0, U64_MAX);
    queue_req(salf_pkg::OP_FACT, 1, S64_MIN);
    queue_req(salf_pkg::OP_FACT, 20, '0);
    queue_req(salf_pkg::OP_FACT, 21, '0);
    queue_req(salf_pkg::OP_FACT, U64_MAX, 7);
    queue_req(salf_pkg::OP_FACT, S64_MIN, S64_MAX);
    queue_req(OW'(5), S64_MAX, S64_MIN);
    queue_req(OW'(6), U64_MAX, U64_MAX);
    queue_req(OW'(7), '0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    for (int c = 0; c < RAND_CHUNKS; c++) begin
      tx_idle_on = (c % 4 != 0 && c != 3);
      rx_idle_on = (c % 4 != 0);
      // sender floods while the receiver holds off, so the input stalls
      if (c == 3) rx_hold_seq++;
      for (int n = 0; n < CHUNK_LEN; n++) queue_random_req();
      // sender pauses here until every outstanding result is back
      wait_drained();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (expected_rsps.size() != 0)
      note_failure($sformatf("%0d responses never arrived", expected_rsps.size()));
    $display("Checked %0d responses: add %0d, sub %0d, mul %0d, div %0d, fact %0d, bad op %0d",
             rsp_count, op_hist[salf_pkg::OP_ADD], op_hist[salf_pkg::OP_SUB],
             op_hist[salf_pkg::OP_MUL], op_hist[salf_pkg::OP_DIV],
             op_hist[salf_pkg::OP_FACT], op_hist[5] + op_hist[6] + op_hist[7]);
    $display("Status seen: ok %0d, div by zero %0d, fact overflow %0d, unknown %0d; %0d failures",
             status_hist[salf_pkg::ST_OK], status_hist[salf_pkg::ST_DIVZERO],
             status_hist[salf_pkg::ST_FACTOVF], status_hist[salf_pkg::ST_UNKNOWN], fail_count);
    if (fail_count == 0) begin
      $display("signed_alu_with_factorial_unit test passed");
    end else begin
      $display("signed_alu_with_factorial_unit test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout: %0d responses still outstanding", expected_rsps.size());
    $display("signed_alu_with_factorial_unit test failed");
    $finish;
  end

endmodule

>>> files.f
rtl/salf_pkg.sv
rtl/salf_req_if.sv
rtl/salf_rsp_if.sv
rtl/salf_addsub.sv
rtl/salf_core.sv
rtl/signed_alu_with_factorial_unit.sv
sim/signed_alu_with_factorial_unit_tb.sv
